>>> rtl/pcdr_pkg.sv
// shared types, constants and helper functions for the pc-aware drrip replacement core
`default_nettype none

package pcdr_pkg;

  // rrip levels and selector limits
  localparam logic [1:0] RRPV_MAX    = 2'd3;
  localparam logic [1:0] RRPV_NEAR   = 2'd2;
  localparam logic [1:0] RRPV_HOT    = 2'd0;
  localparam logic [9:0] SEL_MAX     = 10'd1023;
  localparam logic [9:0] SEL_MID     = 10'd511;
  localparam logic [3:0] HOT_LEVEL   = 4'd12;
  localparam logic [3:0] REUSE_MAX   = 4'd15;
  localparam logic [3:0] DECAY_LEVEL = 4'd8;
  localparam logic [1:0] CONF_MAX    = 2'd3;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;

  // signature table entry: reuse counter, stream confidence, last stride
  localparam int unsigned SIG_DATA_W = 38;
  localparam logic [SIG_DATA_W-1:0] SIG_RESET = {4'd1, 2'd0, 32'd0};

  // widest way number the scanner reports
  localparam int unsigned WAY_NUM_W = 5;

  // item opcodes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROC,
    ST_SCAN,
    ST_DONE
  } pcdr_state_t;

  // scanner status back to the sequencer
  typedef struct packed {
    logic                 done;
    logic [WAY_NUM_W-1:0] way;
    logic [1:0]           top;
  } pcdr_scan_t;

  // signature hash, caller keeps the low bits
  function automatic logic [63:0] sig_hash(input logic [63:0] pc);
    sig_hash = pc ^ (pc >> 13) ^ (pc >> 23);
  endfunction

  // 16-bit lfsr, taps 16,14,13,11, shifting right
  function automatic logic [15:0] lfsr_next(input logic [15:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    lfsr_next = {b, l[15:1]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/pcdr_victim_scan.sv
// way scanner: walks one rrip field per cycle to find the first highest value
`default_nettype none

module pcdr_victim_scan #(
  parameter int unsigned WAYS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [2*WAYS-1:0]      row,
  output pcdr_pkg::pcdr_scan_t        status
);
  import pcdr_pkg::*;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic             busy_r;
  logic             done_r;
  logic [WAY_W-1:0] cnt_r;
  logic [WAY_W-1:0] idx_r;
  logic [1:0]       best_r;
  logic [1:0]       field;

  // current field under the compare unit
  assign field = row[2*cnt_r +: 2];

  // one compare per cycle, first strictly greater wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (32'(cnt_r) == WAYS - 1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best_r <= '0;
      idx_r  <= '0;
    end else if (busy_r && (field > best_r)) begin
      best_r <= field;
      idx_r  <= cnt_r;
    end
  end

  assign status.done = done_r;
  assign status.way  = WAY_NUM_W'(idx_r);
  assign status.top  = best_r;

endmodule

`default_nettype wire

>>> rtl/pc_aware_drrip_replacement_core.sv
// top level: pc-aware drrip replacement core with set and signature memories
// Usage: an item arrives on in_* (valid/ready). op 0 asks for a victim in the
// set, op 1 reports a hit or a miss fill. Each item gives one transaction on
// out_* (valid/ready): victim_way for op 0, inserted_rrpv and stream_seen for
// a miss update, all zero for a hit update.
// Flow: an update passes through the PROC and DONE states from accept to
// out_valid; a victim request passes through PROC, SCAN and DONE, the
// scanner comparing one way's rrip value per cycle. The sequencer takes no
// new item before the last one's result has moved into the output register.
// Reset: after rst_n the block runs a clearing pass of max(SETS, SIG_ENTRIES)
// cycles that sets every rrip value to 3 and every signature entry to its
// reset value; in_ready stays low during the pass.
// Stall: a result waits in the output register while out_ready is low; the
// next item is still accepted and waits in DONE until that result is taken.
`default_nettype none

module pc_aware_drrip_replacement_core #(
  parameter int unsigned SETS        = 2048,
  parameter int unsigned WAYS        = 16,
  parameter int unsigned SIG_ENTRIES = 4096,
  parameter int unsigned LEADERS     = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [10:0] in_set_index,
  input  wire logic [3:0]  in_way_index,
  input  wire logic [63:0] in_pc,
  input  wire logic [63:0] in_phys_addr,
  input  wire logic [63:0] in_evicted_addr,
  input  wire logic        in_was_hit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_victim_way,
  output logic [1:0]       out_inserted_rrpv,
  output logic             out_stream_seen
);
  import pcdr_pkg::*;

  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned SIG_W = $clog2(SIG_ENTRIES);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W = 2 * WAYS;
  localparam int unsigned CLR_N = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
  localparam int unsigned CLR_W = $clog2(CLR_N);

  // memories
  logic [ROW_W-1:0]      rrip_mem [SETS];
  logic [SIG_DATA_W-1:0] sig_mem  [SIG_ENTRIES];

  pcdr_state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // captured item
  logic             op_r;
  logic [SET_W-1:0] set_r;
  logic [WAY_W-1:0] way_r;
  logic             way_ok_r;
  logic [SIG_W-1:0] sig_r;
  logic [31:0]      delta_r;
  logic             hit_r;

  logic [ROW_W-1:0]      row_rd_r;
  logic [SIG_DATA_W-1:0] sig_rd_r;

  logic [9:0]  psel_r, psel_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;

  // result staging and output register
  logic [3:0] res_way_r, res_way_nxt;
  logic [1:0] res_ins_r, res_ins_nxt;
  logic       res_str_r, res_str_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_way_r;
  logic [1:0] out_ins_r;
  logic       out_str_r;
  logic       out_load;

  // memory write controls
  logic                  rrip_we, sig_we;
  logic [SET_W-1:0]      rrip_wa;
  logic [SIG_W-1:0]      sig_wa;
  logic [ROW_W-1:0]      rrip_wd;
  logic [SIG_DATA_W-1:0] sig_wd;

  logic             accept;
  logic [31:0]      set_ext;
  logic [63:0]      hash;
  logic             scan_start;
  pcdr_scan_t       scan;

  // update datapath
  logic [3:0]  reuse, reuse_n;
  logic [1:0]  conf, conf_n;
  logic [31:0] stride;
  logic        stream, lead_s, lead_b, use_b, hot;
  logic [15:0] lfsr_adv;
  logic [1:0]  ins;
  logic [1:0]  add;
  logic [ROW_W-1:0] row_upd, row_aged;

  assign accept  = in_valid && in_ready;
  assign set_ext = 32'(in_set_index);
  assign hash    = sig_hash(in_pc);

  pcdr_victim_scan #(.WAYS(WAYS)) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .row    (row_rd_r),
    .status (scan)
  );

  // capture item at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      set_r    <= set_ext[SET_W-1:0];
      way_r    <= WAY_W'(in_way_index);
      way_ok_r <= 32'(in_way_index) < WAYS;
      sig_r    <= hash[SIG_W-1:0];
      delta_r  <= in_phys_addr[31:0] - in_evicted_addr[31:0];
      hit_r    <= in_was_hit;
    end
  end

  // memory reads registered at accept, writes from the sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd_r <= rrip_mem[set_ext[SET_W-1:0]];
      sig_rd_r <= sig_mem[hash[SIG_W-1:0]];
    end
    if (rrip_we) begin
      rrip_mem[rrip_wa] <= rrip_wd;
    end
    if (sig_we) begin
      sig_mem[sig_wa] <= sig_wd;
    end
  end

  // miss and hit update datapath
  always_comb begin
    reuse  = sig_rd_r[37:34];
    conf   = sig_rd_r[33:32];
    stride = sig_rd_r[31:0];
    if (hit_r) begin
      reuse_n = (reuse < REUSE_MAX) ? reuse + 4'd1 : reuse;
      conf_n  = conf;
    end else begin
      if ((delta_r != 32'd0) && (delta_r == stride)) begin
        conf_n = (conf < CONF_MAX) ? conf + 2'd1 : conf;
      end else begin
        conf_n = 2'd0;
      end
      reuse_n = (reuse > DECAY_LEVEL) ? reuse - 4'd1 : reuse;
    end
    stream   = (conf_n == CONF_MAX);
    lead_s   = 32'(set_r) < LEADERS;
    lead_b   = !lead_s && (32'(set_r) < 2 * LEADERS);
    use_b    = lead_b || (!lead_s && (psel_r > SEL_MID));
    hot      = reuse >= HOT_LEVEL;
    lfsr_adv = lfsr_next(lfsr_r);
    if (stream) begin
      ins = RRPV_MAX;
    end else if (hot) begin
      ins = RRPV_HOT;
    end else if (use_b) begin
      ins = (lfsr_adv[4:0] == 5'd0) ? RRPV_HOT : RRPV_MAX;
    end else begin
      ins = RRPV_NEAR;
    end
    row_upd = row_rd_r;
    if (way_ok_r) begin
      row_upd[2*way_r +: 2] = hit_r ? RRPV_HOT : ins;
    end
  end

  // aged row after a victim scan
  always_comb begin
    add = RRPV_MAX - scan.top;
    for (int w = 0; w < WAYS; w++) begin
      row_aged[2*w +: 2] = row_rd_r[2*w +: 2] + add;
    end
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      psel_r      <= SEL_MID;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      psel_r      <= psel_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_way_r <= res_way_nxt;
    res_ins_r <= res_ins_nxt;
    res_str_r <= res_str_nxt;
    if (out_load) begin
      out_way_r <= res_way_r;
      out_ins_r <= res_ins_r;
      out_str_r <= res_str_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    psel_nxt      = psel_r;
    lfsr_nxt      = lfsr_r;
    res_way_nxt   = res_way_r;
    res_ins_nxt   = res_ins_r;
    res_str_nxt   = res_str_r;
    in_ready      = 1'b0;
    scan_start    = 1'b0;
    out_load      = 1'b0;
    rrip_we       = 1'b0;
    sig_we        = 1'b0;
    rrip_wa       = set_r;
    sig_wa        = sig_r;
    rrip_wd       = row_upd;
    sig_wd        = {reuse_n, conf_n, hit_r ? stride : delta_r};
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_CLEAR: begin
        rrip_we = 32'(clr_cnt_r) < SETS;
        sig_we  = 32'(clr_cnt_r) < SIG_ENTRIES;
        rrip_wa = SET_W'(clr_cnt_r);
        sig_wa  = SIG_W'(clr_cnt_r);
        rrip_wd = {ROW_W{1'b1}};
        sig_wd  = SIG_RESET;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == CLR_N - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        if (op_r == OP_VICTIM) begin
          scan_start = 1'b1;
          state_nxt  = ST_SCAN;
        end else begin
          rrip_we = 1'b1;
          sig_we  = 1'b1;
          res_way_nxt = 4'd0;
          if (hit_r) begin
            res_ins_nxt = 2'd0;
            res_str_nxt = 1'b0;
          end else begin
            res_ins_nxt = ins;
            res_str_nxt = stream;
            if (lead_s && !stream && (psel_r < SEL_MAX)) begin
              psel_nxt = psel_r + 10'd1;
            end else if (lead_b && !stream && (psel_r != 10'd0)) begin
              psel_nxt = psel_r - 10'd1;
            end
            if (!stream && !hot && use_b) begin
              lfsr_nxt = lfsr_adv;
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan.done) begin
          rrip_we     = 1'b1;
          rrip_wd     = row_aged;
          res_way_nxt = scan.way[3:0];
          res_ins_nxt = 2'd0;
          res_str_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_victim_way    = out_way_r;
  assign out_inserted_rrpv = out_ins_r;
  assign out_stream_seen   = out_str_r;

endmodule

`default_nettype wire

>>> test/pc_aware_drrip_replacement_checker.sv
// checker: predicts replacement decisions and compares them with the core's output transactions
`default_nettype none

module pc_aware_drrip_replacement_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_op,
  input  wire logic [10:0] in_set_index,
  input  wire logic [3:0]  in_way_index,
  input  wire logic [63:0] in_pc,
  input  wire logic [63:0] in_phys_addr,
  input  wire logic [63:0] in_evicted_addr,
  input  wire logic        in_was_hit,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [3:0]  out_victim_way,
  input  wire logic [1:0]  out_inserted_rrpv,
  input  wire logic        out_stream_seen,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcdr_pkg::*;

  localparam int NSETS  = 2048;
  localparam int NWAYS  = 16;
  localparam int NSIGS  = 4096;
  localparam int NLEAD  = 64;

  typedef struct packed {
    logic [3:0] way;
    logic [1:0] rrpv;
    logic       stream;
  } decision_t;

  logic [1:0]  rrpv_mem [NSETS][NWAYS];
  logic [3:0]  reuse_mem [NSIGS];
  logic [1:0]  conf_mem [NSIGS];
  logic [31:0] stride_mem [NSIGS];
  logic [9:0]  psel;
  logic [15:0] shift_reg;
  decision_t   expected_q[$];

  // predict the decision for one accepted transaction
  function automatic decision_t predict_decision(logic op, logic [10:0] set, logic [3:0] way,
      logic [63:0] pc, logic [63:0] pa, logic [63:0] ev, logic hit);
    decision_t d;
    logic [63:0] h;
    int idx;
    logic [1:0] top, ins;
    logic [31:0] delta;
    logic strm, lead_s, lead_b, use_b;
    int w;
    d = '0;
    if (op == OP_VICTIM) begin
      top = '0;
      for (w = 0; w < NWAYS; w++) if (rrpv_mem[set][w] > top) top = rrpv_mem[set][w];
      for (w = 0; w < NWAYS; w++) rrpv_mem[set][w] = rrpv_mem[set][w] + (RRPV_MAX - top);
      for (w = 0; w < NWAYS; w++) if (rrpv_mem[set][w] == RRPV_MAX) break;
      d.way = w[3:0];
      return d;
    end
    h = pc ^ (pc >> 13) ^ (pc >> 23);
    idx = int'(h[11:0]);
    if (hit) begin
      rrpv_mem[set][way] = RRPV_HOT;
      if (reuse_mem[idx] < REUSE_MAX) reuse_mem[idx]++;
      return d;
    end
    // stride tracking
    delta = pa[31:0] - ev[31:0];
    if (delta != 32'd0 && delta == stride_mem[idx]) begin
      if (conf_mem[idx] < CONF_MAX) conf_mem[idx]++;
    end else begin
      conf_mem[idx] = 2'd0;
    end
    stride_mem[idx] = delta;
    strm = conf_mem[idx] == CONF_MAX;
    // set dueling
    lead_s = set < NLEAD;
    lead_b = !lead_s && set < 2 * NLEAD;
    use_b = lead_s ? 1'b0 : lead_b ? 1'b1 : (psel > SEL_MID);
    if (lead_s && !strm) begin
      if (psel < SEL_MAX) psel++;
    end else if (lead_b && !strm) begin
      if (psel > 10'd0) psel--;
    end
    // insertion value
    if (strm) ins = RRPV_MAX;
    else if (reuse_mem[idx] >= HOT_LEVEL) ins = RRPV_HOT;
    else if (use_b) begin
      shift_reg = {shift_reg[0] ^ shift_reg[2] ^ shift_reg[3] ^ shift_reg[5], shift_reg[15:1]};
      ins = (shift_reg[4:0] == 5'd0) ? RRPV_HOT : RRPV_MAX;
    end else ins = RRPV_NEAR;
    rrpv_mem[set][way] = ins;
    if (reuse_mem[idx] > DECAY_LEVEL) reuse_mem[idx]--;
    d.rrpv = ins;
    d.stream = strm;
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    for (int s = 0; s < NSETS; s++) for (int w = 0; w < NWAYS; w++) rrpv_mem[s][w] = RRPV_MAX;
    for (int i = 0; i < NSIGS; i++) begin
      reuse_mem[i] = 4'd1;
      conf_mem[i] = '0;
      stride_mem[i] = '0;
    end
    psel = SEL_MID;
    shift_reg = LFSR_SEED;
  end

  // watch both channels
  always @(posedge clk) begin
    decision_t want;
    if (rst_n && in_valid && in_ready)
      expected_q.push_back(predict_decision(in_op, in_set_index, in_way_index, in_pc,
          in_phys_addr, in_evicted_addr, in_was_hit));
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_victim_way != want.way)
          report_mismatch("victim_way", int'(out_victim_way), int'(want.way));
        if (out_inserted_rrpv != want.rrpv)
          report_mismatch("inserted_rrpv", int'(out_inserted_rrpv), int'(want.rrpv));
        if (out_stream_seen != want.stream)
          report_mismatch("stream_seen", int'(out_stream_seen), int'(want.stream));
      end
    end
    pending_count = int'(expected_q.size());
  end
endmodule

`default_nettype wire

>>> test/pc_aware_drrip_replacement_core_test.sv
// testbench top: drives access transactions into the replacement core and gives the verdict
`default_nettype none

module pc_aware_drrip_replacement_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcdr_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_op = 0;
  logic [10:0] in_set_index = 0;
  logic [3:0]  in_way_index = 0;
  logic [63:0] in_pc = 0;
  logic [63:0] in_phys_addr = 0;
  logic [63:0] in_evicted_addr = 0;
  logic        in_was_hit = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [3:0]  out_victim_way;
  logic [1:0]  out_inserted_rrpv;
  logic        out_stream_seen;
  int          fail_count;
  int          pending_count;
  bit          hold_off = 0;

  always #1 clk = ~clk;

  pc_aware_drrip_replacement_core dut (.*);
  pc_aware_drrip_replacement_checker checker_i (.*);

  // stream state for well-formed sequences
  logic [63:0] strm_pc, strm_addr, strm_stride;

  // offer one transaction and wait until it is accepted
  task automatic send_access(logic op, logic [10:0] set, logic [3:0] way, logic [63:0] pc,
      logic [63:0] pa, logic [63:0] ev, logic hit);
    in_valid <= 1;
    in_op <= op;
    in_set_index <= set;
    in_way_index <= way;
    in_pc <= pc;
    in_phys_addr <= pa;
    in_evicted_addr <= ev;
    in_was_hit <= hit;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [10:0] pick_set();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return 11'($urandom_range(0, 63));
    if (k < 6) return 11'($urandom_range(64, 127));
    if (k < 8) return 11'($urandom_range(128, 135));
    return 11'($urandom);
  endfunction

  // one random transaction, mostly from a small pool of pcs so counters move
  task automatic send_random();
    int k;
    logic [63:0] pc;
    logic [63:0] pa;
    k = $urandom_range(0, 99);
    pc = ($urandom_range(0, 3) == 0) ? rand64() : 64'(($urandom_range(0, 7)) << 4);
    if (k < 25) begin
      send_access(OP_VICTIM, pick_set(), 4'($urandom), rand64(), rand64(), rand64(),
          1'($urandom));
    end else if (k < 55) begin
      send_access(OP_UPDATE, pick_set(), 4'($urandom), pc, rand64(), rand64(), 1'b1);
    end else if (k < 80) begin
      // stream continuation
      strm_addr = strm_addr + strm_stride;
      send_access(OP_UPDATE, pick_set(), 4'($urandom), strm_pc, strm_addr + strm_stride,
          strm_addr, 1'b0);
      if ($urandom_range(0, 15) == 0) begin
        strm_pc = rand64();
        strm_stride = 64'($urandom_range(1, 4096));
      end
    end else begin
      pa = rand64();
      send_access(OP_UPDATE, pick_set(), 4'($urandom), pc, pa,
          ($urandom_range(0, 4) == 0) ? pa : rand64(), 1'b0);
    end
  endtask

  // receiver: own stall pattern plus a long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) out_ready <= 0;
      else if (phase % 200 < 60) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // stimulus
  initial begin
    int burst;
    rst_n <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    strm_pc = 64'h40_1000;
    strm_stride = 64'd64;
    strm_addr = 64'h1000;
    // directed: extremes, both ops, hits and misses, out-of-range leaders
    send_access(OP_VICTIM, 11'd0, 4'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    send_access(OP_VICTIM, 11'h7FF, 4'hF, '1, '1, '1, 1'b1);
    send_access(OP_UPDATE, 11'd0, 4'd0, 64'd0, 64'd0, 64'd0, 1'b1);
    send_access(OP_UPDATE, 11'd0, 4'hF, '1, '1, 64'd0, 1'b0);
    send_access(OP_UPDATE, 11'd63, 4'd5, 64'h10, 64'h100, 64'h100, 1'b0);
    send_access(OP_UPDATE, 11'd64, 4'd7, 64'h10, 64'h200, 64'h100, 1'b0);
    send_access(OP_UPDATE, 11'd127, 4'd2, 64'h10, 64'h300, 64'h200, 1'b0);
    send_access(OP_UPDATE, 11'd128, 4'd3, 64'h10, 64'h400, 64'h300, 1'b0);
    send_access(OP_UPDATE, 11'h7FF, 4'd9, 64'h10, 64'h500, 64'h400, 1'b0);
    send_access(OP_UPDATE, 11'h7FF, 4'd9, 64'h10, 64'h600, 64'h500, 1'b0);
    send_access(OP_VICTIM, 11'h7FF, 4'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    send_access(OP_VICTIM, 11'd0, 4'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    for (int i = 0; i < 13; i++)
      send_access(OP_UPDATE, 11'd100, i[3:0], 64'h20, 64'd0, 64'd0, 1'b1);
    send_access(OP_UPDATE, 11'd100, 4'd1, 64'h20, 64'h8000, 64'h10, 1'b0);
    // random part in bursts
    for (int n = 0; n < 1350; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++) send_random();
      n += burst;
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
      if (n > 400 && n <= 400 + burst) begin
        // long hold-off while the sender keeps offering
        hold_off = 1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          for (int b = 0; b < 5; b++) send_random();
        join
      end
      if (n > 800 && n <= 800 + burst) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
rtl/pcdr_pkg.sv
rtl/pcdr_victim_scan.sv
rtl/pc_aware_drrip_replacement_core.sv
test/pc_aware_drrip_replacement_checker.sv
test/pc_aware_drrip_replacement_core_test.sv
